// ===== hdl/lpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants of the Lagrangian pressure predictor: defaults of
// the number format, register indexes and reset values, the operation codes of
// the saturating adder, and the transaction payloads of both channels.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_WIDTH       = 31;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIME_STEP   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_HEIGHT = 2'd2;

  localparam logic [CFG_WIDTH-1:0] TIME_STEP_RESET   = 31'd6554;
  localparam logic [CFG_WIDTH-1:0] CELL_WIDTH_RESET  = 31'd65536;
  localparam logic [CFG_WIDTH-1:0] CELL_HEIGHT_RESET = 31'd65536;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_SUB      = 2'd1,
    OP_NEG_PART = 2'd2
  } add_op_t;

  typedef struct packed {
    logic signed [31:0] vel_x_sw;
    logic signed [31:0] vel_x_se;
    logic signed [31:0] vel_x_nw;
    logic signed [31:0] vel_x_ne;
    logic signed [31:0] vel_y_sw;
    logic signed [31:0] vel_y_se;
    logic signed [31:0] vel_y_nw;
    logic signed [31:0] vel_y_ne;
    logic        [30:0] cell_mass;
    logic signed [31:0] cell_energy;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] pressure;
    logic signed [31:0] predicted_pressure;
    logic signed [31:0] pseudo_pressure;
    logic               saturated;
  } result_t;

endpackage

// ===== hdl/lpp_stream_if.sv =====
// ----------------------------------------------------------------------------
// lpp_stream_if
// Valid/ready channel; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface lpp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/lpp_delay.sv =====
// ----------------------------------------------------------------------------
// lpp_delay
// Shift line that keeps an operand aligned with the pipeline; it advances
// only when the pipeline advances.
// ----------------------------------------------------------------------------
module lpp_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [WIDTH-1:0] line [DEPTH];
      always_ff @(posedge clk) begin
        if (en) begin
          line[0] <= d;
          for (int i = 1; i < DEPTH; i++) begin
            line[i] <= line[i-1];
          end
        end
      end
      assign q = line[DEPTH-1];
    end
  endgenerate

endmodule

// ===== hdl/lpp_add.sv =====
// ----------------------------------------------------------------------------
// lpp_add
// Saturating fixed-point add, subtract or negative part, one register stage.
// Operands carry a saturation mark in their top bit.
// ----------------------------------------------------------------------------
module lpp_add import lpp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  add_op_t             op,
  input  logic [DATA_WIDTH:0] a,
  input  logic [DATA_WIDTH:0] b,
  output logic [DATA_WIDTH:0] y
);

  localparam int DW = DATA_WIDTH;
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW:0] sa;
  logic signed [DW:0] sb;
  logic signed [DW:0] sum;
  logic               ovf;
  logic [DW-1:0]      res;

  assign sa = {a[DW-1], a[DW-1:0]};
  assign sb = {b[DW-1], b[DW-1:0]};

  always_comb begin
    case (op)
      OP_ADD:      sum = sa + sb;
      OP_SUB:      sum = sa - sb;
      OP_NEG_PART: sum = a[DW-1] ? -sa : '0;
      default:     sum = sa + sb;
    endcase
  end

  assign ovf = sum[DW] != sum[DW-1];
  assign res = ovf ? (sum[DW] ? MINV : MAXV) : sum[DW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      y <= {a[DW] | b[DW] | ovf, res};
    end
  end

endmodule

// ===== hdl/lpp_mul.sv =====
// ----------------------------------------------------------------------------
// lpp_mul
// Saturating fixed-point multiply in three stages: half-width partial
// products, their sum, then the fraction shift and the clamp.
// ----------------------------------------------------------------------------
module lpp_mul import lpp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DATA_WIDTH:0] a,
  input  logic [DATA_WIDTH:0] b,
  output logic [DATA_WIDTH:0] y
);

  localparam int DW = DATA_WIDTH;
  localparam int H  = (DW + 1) / 2;
  localparam int LW = DW - H;
  localparam int PW = 2 * DW;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  logic [DW-1:0]      ma;
  logic [DW-1:0]      mb;
  logic [2*H-1:0]     p00;
  logic [H+LW-1:0]    p01;
  logic [H+LW-1:0]    p10;
  logic [2*LW-1:0]    p11;
  logic               neg1;
  logic               sat1;
  logic [PW-1:0]      prod;
  logic               neg2;
  logic               sat2;
  logic [PW-1:0]      shifted;
  logic [PW-1:0]      lim;
  logic               ovf;
  logic [DW-1:0]      mres;

  assign ma = mag(a[DW-1:0]);
  assign mb = mag(b[DW-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      p00  <= (2*H)'(ma[H-1:0]) * (2*H)'(mb[H-1:0]);
      p01  <= (H+LW)'(ma[H-1:0]) * (H+LW)'(mb[DW-1:H]);
      p10  <= (H+LW)'(ma[DW-1:H]) * (H+LW)'(mb[H-1:0]);
      p11  <= (2*LW)'(ma[DW-1:H]) * (2*LW)'(mb[DW-1:H]);
      neg1 <= a[DW-1] ^ b[DW-1];
      sat1 <= a[DW] | b[DW];
      prod <= PW'(p00) + (PW'(p01) << H) + (PW'(p10) << H) + (PW'(p11) << (2*H));
      neg2 <= neg1;
      sat2 <= sat1;
    end
  end

  assign shifted = prod >> FRAC_BITS;
  assign lim     = neg2 ? PW'({1'b1, {(DW-1){1'b0}}}) : PW'({1'b0, {(DW-1){1'b1}}});
  assign ovf     = shifted > lim;
  assign mres    = ovf ? lim[DW-1:0] : shifted[DW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      y <= {sat2 | ovf, neg2 ? (~mres + 1'b1) : mres};
    end
  end

endmodule

// ===== hdl/lpp_div.sv =====
// ----------------------------------------------------------------------------
// lpp_div
// Saturating fixed-point divide: a setup stage, one restoring quotient bit
// per stage, and a clamp stage. Division by zero gives the extreme of the
// dividend's sign, or zero for a zero dividend.
// ----------------------------------------------------------------------------
module lpp_div import lpp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DATA_WIDTH:0] a,
  input  logic [DATA_WIDTH:0] b,
  output logic [DATA_WIDTH:0] y
);

  localparam int DW = DATA_WIDTH;
  localparam int NW = DW + FRAC_BITS;
  localparam int CW = ((FRAC_BITS > DW) ? FRAC_BITS : DW) + 1;
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic neg;
    logic ovf;
    logic zero;
    logic a_zero;
    logic a_neg;
    logic sat_in;
  } div_flags_t;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  logic [DW-1:0]    ma;
  logic [DW-1:0]    mb;
  logic [NW-1:0]    num;
  div_flags_t       f_in;

  logic [DW-1:0]    rem   [DW+1];
  logic [DW-1:0]    quo   [DW+1];
  logic [DW-1:0]    nl    [DW+1];
  logic [DW-1:0]    mbs   [DW+1];
  div_flags_t       flags [DW+1];

  logic [DW:0]      trial [DW];
  logic             ge    [DW];
  logic [DW-1:0]    diff  [DW];

  logic [DW-1:0]    lim;
  logic             qovf;
  logic [DW-1:0]    qm;
  logic [DW-1:0]    qres;
  logic             qsat;

  assign ma  = mag(a[DW-1:0]);
  assign mb  = mag(b[DW-1:0]);
  assign num = NW'(ma) << FRAC_BITS;

  always_comb begin
    f_in.neg    = a[DW-1] ^ b[DW-1];
    f_in.ovf    = CW'(num[NW-1:DW]) >= CW'(mb);
    f_in.zero   = b[DW-1:0] == '0;
    f_in.a_zero = a[DW-1:0] == '0;
    f_in.a_neg  = a[DW-1];
    f_in.sat_in = a[DW] | b[DW];
  end

  always_comb begin
    for (int k = 0; k < DW; k++) begin
      trial[k] = {rem[k], nl[k][DW-1]};
      ge[k]    = trial[k] >= {1'b0, mbs[k]};
      diff[k]  = DW'(trial[k] - {1'b0, mbs[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= DW'(num[NW-1:DW]);
      quo[0]   <= '0;
      nl[0]    <= num[DW-1:0];
      mbs[0]   <= mb;
      flags[0] <= f_in;
      for (int k = 0; k < DW; k++) begin
        rem[k+1]   <= ge[k] ? diff[k] : trial[k][DW-1:0];
        quo[k+1]   <= {quo[k][DW-2:0], ge[k]};
        nl[k+1]    <= nl[k] << 1;
        mbs[k+1]   <= mbs[k];
        flags[k+1] <= flags[k];
      end
    end
  end

  assign lim  = flags[DW].neg ? MINV : MAXV;
  assign qovf = flags[DW].ovf || (quo[DW] > lim);
  assign qm   = qovf ? lim : quo[DW];

  always_comb begin
    if (flags[DW].zero) begin
      qsat = 1'b1;
      if (flags[DW].a_zero) begin
        qres = '0;
      end else begin
        qres = flags[DW].a_neg ? MINV : MAXV;
      end
    end else begin
      qsat = qovf;
      qres = flags[DW].neg ? (~qm + 1'b1) : qm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= {flags[DW].sat_in | qsat, qres};
    end
  end

endmodule

// ===== hdl/lpp_sqrt.sv =====
// ----------------------------------------------------------------------------
// lpp_sqrt
// Fixed-point square root: a setup stage, one root bit per stage, and a
// clamp stage. A negative radicand gives zero and marks saturation.
// ----------------------------------------------------------------------------
module lpp_sqrt import lpp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DATA_WIDTH:0] a,
  output logic [DATA_WIDTH:0] y
);

  localparam int DW = DATA_WIDTH;
  localparam int NW = DW - 1 + FRAC_BITS;
  localparam int SW = (NW + 1) / 2;
  localparam int RW = 2 * SW + 2;
  localparam int CW = (SW > DW) ? SW : DW;
  localparam logic [CW-1:0] LIM = CW'({(DW-1){1'b1}});

  logic [RW-1:0] rem   [SW+1];
  logic [SW-1:0] root  [SW+1];
  logic          neg   [SW+1];
  logic          sat   [SW+1];

  logic [RW-1:0] trial [SW];
  logic          ge    [SW];

  logic          rovf;

  always_comb begin
    for (int k = 0; k < SW; k++) begin
      trial[k] = (RW'(root[k]) << (SW - k)) + (RW'(1) << (2 * (SW - 1 - k)));
      ge[k]    = trial[k] <= rem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RW'(a[DW-2:0]) << FRAC_BITS;
      root[0] <= '0;
      neg[0]  <= a[DW-1];
      sat[0]  <= a[DW];
      for (int k = 0; k < SW; k++) begin
        rem[k+1]  <= ge[k] ? (rem[k] - trial[k]) : rem[k];
        root[k+1] <= ge[k] ? (root[k] | (SW'(1) << (SW - 1 - k))) : root[k];
        neg[k+1]  <= neg[k];
        sat[k+1]  <= sat[k];
      end
    end
  end

  assign rovf = CW'(root[SW]) > LIM;

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[SW]) begin
        y <= {1'b1, {DW{1'b0}}};
      end else if (rovf) begin
        y <= {1'b1, DW'(LIM)};
      end else begin
        y <= {sat[SW], DW'(root[SW])};
      end
    end
  end

endmodule

// ===== hdl/lagrange_pressure_predictor.sv =====
// ----------------------------------------------------------------------------
// lagrange_pressure_predictor
// Per-cell pressure, half-step predicted pressure and artificial-viscosity
// pressure of a staggered-grid Lagrangian hydro step, in saturating signed
// fixed point.
//
//   Channel   Kind          Payload    Width
//   cells     stream in     cell_t     319
//   results   stream out    result_t   97
//   cfg_*     write port    register   31
//
// One transaction enters every cycle while the output is not stalled; the
// longest path, to the predicted pressure, runs through a chain of three
// bit-per-stage dividers and the root extraction.
// Reset clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline, and ready follows it.
// ----------------------------------------------------------------------------
module lagrange_pressure_predictor import lpp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  lpp_stream_if.sink                 cells,
  lpp_stream_if.source               results
);

  localparam int DW = DATA_WIDTH;
  localparam int VW = DW + 1;
  localparam int SW = (DW + FRAC_BITS) / 2;
  localparam int M  = 3;
  localparam int D  = DW + 2;
  localparam int S  = SW + 2;

  localparam int T0     = 1;
  localparam int T_A    = T0 + M;
  localparam int T_DV   = T0 + 1;
  localparam int T_DVM  = T_DV + 1;
  localparam int T_S    = T_A + 1;
  localparam int T_DVOL = T_S + M;
  localparam int T_DIVX = T0 + D;
  localparam int T_DIVU = T_DIVX + 1;
  localparam int T_RHO  = T_A + D;
  localparam int T_GR   = T_RHO + M;
  localparam int T_P    = T_GR + M;
  localparam int T_GP   = T_P + M;
  localparam int T_RAT  = T_GP + D;
  localparam int T_CS   = T_RAT + S;
  localparam int T_RD   = T_RHO + M;
  localparam int T_CSD  = T_CS + 1;
  localparam int T_Q    = T_CSD + M;
  localparam int T_PQ   = T_Q + 1;
  localparam int T_HPQ  = T_PQ + M;
  localparam int T_HD   = T_HPQ + M;
  localparam int T_F    = T_HD + D;
  localparam int T_E2   = T_F + 1;
  localparam int T_AD   = T_DVOL + 1;
  localparam int T_PRHO = T_AD + D;
  localparam int T_GPR  = T_PRHO + M;
  localparam int T_PP   = T_E2 + M;

  localparam longint unsigned G_RAW  = ((64'd14 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam longint unsigned G1_RAW = ((64'd4 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [DW:0] GAMMA    = {1'b0, DW'(G_RAW)};
  localparam logic [DW:0] GAMMA_M1 = {1'b0, DW'(G1_RAW)};

  localparam logic signed [65:0] FIX_MAX = (66'sd1 <<< (DW - 1)) - 66'sd1;
  localparam logic signed [65:0] FIX_MIN = -(66'sd1 <<< (DW - 1));

  function automatic logic [DW:0] to_fix(input logic signed [65:0] v);
    if (v > FIX_MAX) begin
      return {1'b1, FIX_MAX[DW-1:0]};
    end else if (v < FIX_MIN) begin
      return {1'b1, FIX_MIN[DW-1:0]};
    end else begin
      return {1'b0, v[DW-1:0]};
    end
  endfunction

  function automatic logic [31:0] low_word(input logic [DW-1:0] v);
    logic signed [63:0] x;
    x = 64'(signed'(v));
    return x[31:0];
  endfunction

  logic [CFG_WIDTH-1:0] time_step;
  logic [CFG_WIDTH-1:0] cell_width;
  logic [CFG_WIDTH-1:0] cell_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= TIME_STEP_RESET;
      cell_width  <= CELL_WIDTH_RESET;
      cell_height <= CELL_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_STEP:   time_step   <= cfg_data;
        REG_CELL_WIDTH:  cell_width  <= cfg_data;
        REG_CELL_HEIGHT: cell_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic vld [T_PP];

  assign en          = !vld[T_PP-1] || results.ready;
  assign cells.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < T_PP; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= cells.valid;
      for (int i = 1; i < T_PP; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  logic signed [33:0] sum_x;
  logic signed [33:0] sum_y;
  logic signed [33:0] half_x;
  logic signed [33:0] half_y;
  logic [DW:0] dt_w, dx_w, dy_w, m_w, e_w, dux_w, duy_w;
  logic        sat_w;

  always_comb begin
    sum_x  = 34'(cells.payload.vel_x_se) + 34'(cells.payload.vel_x_ne)
           - 34'(cells.payload.vel_x_sw) - 34'(cells.payload.vel_x_nw);
    sum_y  = 34'(cells.payload.vel_y_nw) + 34'(cells.payload.vel_y_ne)
           - 34'(cells.payload.vel_y_sw) - 34'(cells.payload.vel_y_se);
    half_x = (sum_x + (sum_x[33] ? 34'sd1 : 34'sd0)) >>> 1;
    half_y = (sum_y + (sum_y[33] ? 34'sd1 : 34'sd0)) >>> 1;
    dt_w   = to_fix({35'd0, time_step});
    dx_w   = to_fix({35'd0, cell_width});
    dy_w   = to_fix({35'd0, cell_height});
    m_w    = to_fix({35'd0, cells.payload.cell_mass});
    e_w    = to_fix({{34{cells.payload.cell_energy[31]}}, cells.payload.cell_energy});
    dux_w  = to_fix({{32{half_x[33]}}, half_x});
    duy_w  = to_fix({{32{half_y[33]}}, half_y});
    sat_w  = dt_w[DW] | dx_w[DW] | dy_w[DW] | m_w[DW] | e_w[DW] | dux_w[DW] | duy_w[DW];
  end

  logic [DW:0] hdt0, dx0, dy0, m0, e0, dux0, duy0;

  always_ff @(posedge clk) begin
    if (en) begin
      hdt0 <= {sat_w, 1'b0, dt_w[DW-1:1]};
      dx0  <= {sat_w, dx_w[DW-1:0]};
      dy0  <= {sat_w, dy_w[DW-1:0]};
      m0   <= {sat_w, m_w[DW-1:0]};
      e0   <= {sat_w, e_w[DW-1:0]};
      dux0 <= {sat_w, dux_w[DW-1:0]};
      duy0 <= {sat_w, duy_w[DW-1:0]};
    end
  end

  logic [DW:0] area, mdy, mdx, dv, dvm, s_sum, hdt_s, dvol;
  logic [DW:0] divx, divy, divu, m_a, rho, gr, e_gr, p, gp, rho_gp, ratio, cs;
  logic [DW:0] dvm_rho, rd, dvm_cs, csd, rd_d, q, p_q, pq, hdt_pq, hpq, divu_d, hd;
  logic [DW:0] rho_hd, f, e_f, e2, area_d, ad, m_ad, prho, gpr, gpr_d, pp, p_out, q_out;

  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_area (
    .clk(clk), .en(en), .a(dx0), .b(dy0), .y(area));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_mdy (
    .clk(clk), .en(en), .a(dux0), .b(dy0), .y(mdy));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_mdx (
    .clk(clk), .en(en), .a(duy0), .b(dx0), .y(mdx));
  lpp_add #(.DATA_WIDTH(DW)) u_dv (
    .clk(clk), .en(en), .op(OP_ADD), .a(dux0), .b(duy0), .y(dv));
  lpp_add #(.DATA_WIDTH(DW)) u_dvm (
    .clk(clk), .en(en), .op(OP_NEG_PART), .a(dv), .b(dv), .y(dvm));
  lpp_add #(.DATA_WIDTH(DW)) u_s (
    .clk(clk), .en(en), .op(OP_ADD), .a(mdy), .b(mdx), .y(s_sum));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_S - T0)) d_hdt_s (
    .clk(clk), .en(en), .d(hdt0), .q(hdt_s));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_dvol (
    .clk(clk), .en(en), .a(hdt_s), .b(s_sum), .y(dvol));

  lpp_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_divx (
    .clk(clk), .en(en), .a(dux0), .b(dx0), .y(divx));
  lpp_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_divy (
    .clk(clk), .en(en), .a(duy0), .b(dy0), .y(divy));
  lpp_add #(.DATA_WIDTH(DW)) u_divu (
    .clk(clk), .en(en), .op(OP_ADD), .a(divx), .b(divy), .y(divu));

  lpp_delay #(.WIDTH(VW), .DEPTH(T_A - T0)) d_m_a (
    .clk(clk), .en(en), .d(m0), .q(m_a));
  lpp_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_rho (
    .clk(clk), .en(en), .a(m_a), .b(area), .y(rho));

  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_gr (
    .clk(clk), .en(en), .a(GAMMA_M1), .b(rho), .y(gr));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_GR - T0)) d_e_gr (
    .clk(clk), .en(en), .d(e0), .q(e_gr));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_p (
    .clk(clk), .en(en), .a(gr), .b(e_gr), .y(p));

  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_gp (
    .clk(clk), .en(en), .a(GAMMA), .b(p), .y(gp));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_GP - T_RHO)) d_rho_gp (
    .clk(clk), .en(en), .d(rho), .q(rho_gp));
  lpp_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_ratio (
    .clk(clk), .en(en), .a(gp), .b(rho_gp), .y(ratio));
  lpp_sqrt #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_cs (
    .clk(clk), .en(en), .a(ratio), .y(cs));

  lpp_delay #(.WIDTH(VW), .DEPTH(T_RHO - T_DVM)) d_dvm_rho (
    .clk(clk), .en(en), .d(dvm), .q(dvm_rho));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_rd (
    .clk(clk), .en(en), .a(rho), .b(dvm_rho), .y(rd));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_CS - T_DVM)) d_dvm_cs (
    .clk(clk), .en(en), .d(dvm), .q(dvm_cs));
  lpp_add #(.DATA_WIDTH(DW)) u_csd (
    .clk(clk), .en(en), .op(OP_ADD), .a(cs), .b(dvm_cs), .y(csd));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_CSD - T_RD)) d_rd (
    .clk(clk), .en(en), .d(rd), .q(rd_d));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_q (
    .clk(clk), .en(en), .a(rd_d), .b(csd), .y(q));

  lpp_delay #(.WIDTH(VW), .DEPTH(T_Q - T_P)) d_p_q (
    .clk(clk), .en(en), .d(p), .q(p_q));
  lpp_add #(.DATA_WIDTH(DW)) u_pq (
    .clk(clk), .en(en), .op(OP_ADD), .a(p_q), .b(q), .y(pq));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_PQ - T0)) d_hdt_pq (
    .clk(clk), .en(en), .d(hdt0), .q(hdt_pq));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_hpq (
    .clk(clk), .en(en), .a(hdt_pq), .b(pq), .y(hpq));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_HPQ - T_DIVU)) d_divu (
    .clk(clk), .en(en), .d(divu), .q(divu_d));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_hd (
    .clk(clk), .en(en), .a(hpq), .b(divu_d), .y(hd));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_HD - T_RHO)) d_rho_hd (
    .clk(clk), .en(en), .d(rho), .q(rho_hd));
  lpp_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_f (
    .clk(clk), .en(en), .a(hd), .b(rho_hd), .y(f));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_F - T0)) d_e_f (
    .clk(clk), .en(en), .d(e0), .q(e_f));
  lpp_add #(.DATA_WIDTH(DW)) u_e2 (
    .clk(clk), .en(en), .op(OP_SUB), .a(e_f), .b(f), .y(e2));

  lpp_delay #(.WIDTH(VW), .DEPTH(T_DVOL - T_A)) d_area (
    .clk(clk), .en(en), .d(area), .q(area_d));
  lpp_add #(.DATA_WIDTH(DW)) u_ad (
    .clk(clk), .en(en), .op(OP_ADD), .a(area_d), .b(dvol), .y(ad));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_AD - T0)) d_m_ad (
    .clk(clk), .en(en), .d(m0), .q(m_ad));
  lpp_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_prho (
    .clk(clk), .en(en), .a(m_ad), .b(ad), .y(prho));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_gpr (
    .clk(clk), .en(en), .a(GAMMA_M1), .b(prho), .y(gpr));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_E2 - T_GPR)) d_gpr (
    .clk(clk), .en(en), .d(gpr), .q(gpr_d));
  lpp_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_pp (
    .clk(clk), .en(en), .a(gpr_d), .b(e2), .y(pp));

  lpp_delay #(.WIDTH(VW), .DEPTH(T_PP - T_P)) d_p_out (
    .clk(clk), .en(en), .d(p), .q(p_out));
  lpp_delay #(.WIDTH(VW), .DEPTH(T_PP - T_Q)) d_q_out (
    .clk(clk), .en(en), .d(q), .q(q_out));

  // Every intermediate value feeds the predicted pressure, so its mark
  // carries the saturation of the whole cell.
  assign results.valid                      = vld[T_PP-1];
  assign results.payload.pressure           = low_word(p_out[DW-1:0]);
  assign results.payload.predicted_pressure = low_word(pp[DW-1:0]);
  assign results.payload.pseudo_pressure    = low_word(q_out[DW-1:0]);
  assign results.payload.saturated          = pp[DW];

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(results.payload))
    else $error("result payload changed while the pipeline was stalled");

  a_pseudo_nonneg: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !q_out[DW-1])
    else $error("pseudo pressure of a valid transaction is negative");

endmodule

// ===== tb/sv/lpp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpp_checker
// Watches the register port and both channels of the pressure predictor,
// computes the expected pressures and saturation flag of every accepted cell
// and compares each result transaction, in order, with the oldest one.
// ----------------------------------------------------------------------------
module lpp_checker import lpp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  lpp_stream_if                      cells,
  lpp_stream_if                      results,
  output int                         failures,
  output int                         pending
);

  localparam int          FRAC      = FRAC_BITS_DEF;
  localparam longint      GAMMA     = ((64'd14 << FRAC) + 64'd5) / 64'd10;
  localparam longint      GAMMA_M1  = ((64'd4 << FRAC) + 64'd5) / 64'd10;
  localparam bit [127:0]  POS_LIMIT = 128'h7fff_ffff;
  localparam bit [127:0]  NEG_LIMIT = 128'h8000_0000;

  logic [CFG_WIDTH-1:0] step_q;
  logic [CFG_WIDTH-1:0] width_q;
  logic [CFG_WIDTH-1:0] height_q;
  bit                   clipped;
  result_t              expected_results[$];

  function automatic bit [127:0] abs_of(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint clamp(bit neg, bit [127:0] mag);
    bit [127:0] lim;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    if (mag > lim) begin
      clipped = 1'b1;
      mag = lim;
    end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint add_mag(bit na, bit [127:0] ma, bit nb, bit [127:0] mb);
    if (na == nb) return clamp(na, ma + mb);
    if (ma >= mb) return clamp(na, ma - mb);
    return clamp(nb, mb - ma);
  endfunction

  function automatic longint fix_add(longint a, longint b);
    return add_mag(a < 0, abs_of(a), b < 0, abs_of(b));
  endfunction

  function automatic longint fix_sub(longint a, longint b);
    return add_mag(a < 0, abs_of(a), !(b < 0), abs_of(b));
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    return clamp((a < 0) != (b < 0), (abs_of(a) * abs_of(b)) >> FRAC);
  endfunction

  function automatic longint fix_div(longint a, longint b);
    if (b == 0) begin
      clipped = 1'b1;
      return (a == 0) ? 0 : clamp(a < 0, 128'h1 << 64);
    end
    return clamp((a < 0) != (b < 0), (abs_of(a) << FRAC) / abs_of(b));
  endfunction

  function automatic longint fix_sqrt(longint a);
    bit [127:0] rad;
    bit [127:0] root;
    bit [127:0] trial;
    if (a < 0) begin
      clipped = 1'b1;
      return 0;
    end
    rad  = abs_of(a) << FRAC;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (128'h1 << i);
      if (trial * trial <= rad) root = trial;
    end
    return clamp(1'b0, root);
  endfunction

  function automatic result_t cell_pressures(cell_t c);
    longint dt, hdt, dx, dy, m, e, area, rho, p, dux, duy, dvol, dv;
    longint cs, dvm, q, divu, e2, prho, pp;
    result_t r;
    clipped = 1'b0;
    dt  = clamp(1'b0, 128'(step_q));
    dx  = clamp(1'b0, 128'(width_q));
    dy  = clamp(1'b0, 128'(height_q));
    m   = clamp(1'b0, 128'(c.cell_mass));
    e   = longint'(c.cell_energy);
    hdt = dt / 2;
    dux = (longint'(c.vel_x_se) + longint'(c.vel_x_ne)
           - longint'(c.vel_x_sw) - longint'(c.vel_x_nw)) / 2;
    dux = clamp(dux < 0, abs_of(dux));
    duy = (longint'(c.vel_y_nw) + longint'(c.vel_y_ne)
           - longint'(c.vel_y_sw) - longint'(c.vel_y_se)) / 2;
    duy = clamp(duy < 0, abs_of(duy));
    area = fix_mul(dx, dy);
    rho  = fix_div(m, area);
    p    = fix_mul(fix_mul(GAMMA_M1, rho), e);
    dvol = fix_mul(hdt, fix_add(fix_mul(dux, dy), fix_mul(duy, dx)));
    dv   = fix_add(dux, duy);
    cs   = fix_sqrt(fix_div(fix_mul(GAMMA, p), rho));
    dvm  = (dv < 0) ? clamp(1'b0, abs_of(dv)) : 0;
    q    = fix_mul(fix_mul(rho, dvm), fix_add(cs, dvm));
    divu = fix_add(fix_div(dux, dx), fix_div(duy, dy));
    e2   = fix_sub(e, fix_div(fix_mul(fix_mul(hdt, fix_add(p, q)), divu), rho));
    prho = fix_div(m, fix_add(area, dvol));
    pp   = fix_mul(fix_mul(GAMMA_M1, prho), e2);
    r.pressure           = p[31:0];
    r.predicted_pressure = pp[31:0];
    r.pseudo_pressure    = q[31:0];
    r.saturated          = clipped;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
    failures++;
  endtask

  assign pending = expected_results.size();

  initial failures = 0;

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      step_q   <= TIME_STEP_RESET;
      width_q  <= CELL_WIDTH_RESET;
      height_q <= CELL_HEIGHT_RESET;
      expected_results.delete();
    end else begin
      if (cells.valid && cells.ready) begin
        expected_results.push_back(cell_pressures(cells.payload));
      end
      if (results.valid && results.ready) begin
        got = results.payload;
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $realtime);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got.pressure !== want.pressure)
            report("pressure", got.pressure, want.pressure);
          if (got.predicted_pressure !== want.predicted_pressure)
            report("predicted_pressure", got.predicted_pressure, want.predicted_pressure);
          if (got.pseudo_pressure !== want.pseudo_pressure)
            report("pseudo_pressure", got.pseudo_pressure, want.pseudo_pressure);
          if (got.saturated !== want.saturated)
            report("saturated", got.saturated, want.saturated);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_TIME_STEP:   step_q   <= cfg_data;
          REG_CELL_WIDTH:  width_q  <= cfg_data;
          REG_CELL_HEIGHT: height_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random cells through the pressure predictor under
// several register settings and idling patterns on both channels; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import lpp_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 2'd3;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CELLS_PER_SET  = 100;
  localparam int MAX_REG        = 32'h7fff_ffff;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;
  int                         failures;
  int                         pending;
  int                         send_idle_pct;
  int                         recv_stall_pct;
  int                         quiet_cycles;

  lpp_stream_if #(.T(cell_t))   cells_if ();
  lpp_stream_if #(.T(result_t)) results_if ();

  lagrange_pressure_predictor i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cells    (cells_if.sink),
    .results  (results_if.source)
  );

  lpp_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cells    (cells_if),
    .results  (results_if),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (cells_if.valid && cells_if.ready) || (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [31:0] random_q();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      2: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
      default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    c.vel_x_sw    = random_q();
    c.vel_x_se    = random_q();
    c.vel_x_nw    = random_q();
    c.vel_x_ne    = random_q();
    c.vel_y_sw    = random_q();
    c.vel_y_se    = random_q();
    c.vel_y_nw    = random_q();
    c.vel_y_ne    = random_q();
    case ($urandom_range(3))
      0: c.cell_mass = $urandom;
      1: c.cell_mass = 31'($urandom_range(32'h0000_0100));
      default: c.cell_mass = 31'($urandom_range(32'h0004_0000));
    endcase
    c.cell_energy = ($urandom_range(4) == 0) ? random_q()
                                             : $signed(32'($urandom_range(32'h0020_0000)));
    return c;
  endfunction

  function automatic cell_t uniform_cell(int ux, int uy, int mass, int energy);
    cell_t c;
    c.vel_x_sw    = -ux;
    c.vel_x_nw    = -ux;
    c.vel_x_se    = ux;
    c.vel_x_ne    = ux;
    c.vel_y_sw    = -uy;
    c.vel_y_se    = -uy;
    c.vel_y_nw    = uy;
    c.vel_y_ne    = uy;
    c.cell_mass   = 31'(mass);
    c.cell_energy = energy;
    return c;
  endfunction

  task automatic send_cell(cell_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cells_if.valid <= 1'b0;
      @(negedge clk);
    end
    cells_if.valid   <= 1'b1;
    cells_if.payload <= c;
    do @(posedge clk); while (!cells_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    cells_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_setting(int dt, int dx, int dy);
    drain();
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_CELL_WIDTH, dx);
    write_reg(REG_CELL_HEIGHT, dy);
    write_reg(REG_UNMAPPED, $urandom);
  endtask

  initial begin
    cell_t c;
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = REG_TIME_STEP;
    cfg_data         = '0;
    cells_if.valid   = 1'b0;
    cells_if.payload = '0;
    results_if.ready = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    quiet_cycles     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_cell(uniform_cell(0, 0, 0, 0));
    send_cell(uniform_cell(0, 0, 32'h0001_0000, 32'h0001_0000));
    send_cell(uniform_cell(-32'h0000_8000, 0, 32'h0001_0000, 32'h0002_0000));
    send_cell(uniform_cell(0, -32'h0000_8000, 32'h0002_0000, 32'h0001_0000));
    send_cell(uniform_cell(32'h0000_4000, 32'h0000_4000, 32'h0001_0000, 32'h0001_0000));
    send_cell(uniform_cell(0, 0, 32'h0001_0000, -32'h0001_0000));
    send_cell(uniform_cell(0, 0, MAX_REG, 32'h7fff_ffff));
    send_cell(uniform_cell(0, 0, 1, 32'h8000_0000));
    send_cell(uniform_cell(-32'h0001_0000, -32'h0001_0000, 0, 32'h0001_0000));
    send_cell(uniform_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000, 32'h0001_0000));
    send_cell(uniform_cell(32'h8000_0000, 32'h8000_0000, MAX_REG, 32'h7fff_ffff));
    c = '1;
    send_cell(c);
    c = '0;
    c.vel_x_sw = 32'sh8000_0000;
    c.vel_x_nw = 32'sh8000_0000;
    c.vel_x_se = 32'sh7fff_ffff;
    c.vel_x_ne = 32'sh7fff_ffff;
    c.cell_mass = 31'h0001_0000;
    c.cell_energy = 32'sh0001_0000;
    send_cell(c);
    c = '0;
    c.vel_y_sw = 32'sh7fff_ffff;
    c.vel_y_se = 32'sh7fff_ffff;
    c.vel_y_nw = 32'sh8000_0000;
    c.vel_y_ne = 32'sh8000_0000;
    c.cell_mass = 31'h0001_0000;
    c.cell_energy = 32'sh0010_0000;
    send_cell(c);

    load_setting(0, 0, 0);
    send_cell(uniform_cell(-32'h0000_8000, 32'h0000_4000, 32'h0001_0000, 32'h0001_0000));
    send_cell(uniform_cell(0, 0, 0, 32'h0001_0000));
    load_setting(MAX_REG, MAX_REG, MAX_REG);
    send_cell(uniform_cell(-32'h0000_8000, -32'h0000_8000, MAX_REG, 32'h0001_0000));
    send_cell(uniform_cell(32'h0000_8000, 32'h0000_8000, 32'h0001_0000, -32'h0001_0000));
    load_setting(0, 1, 1);
    send_cell(uniform_cell(-32'h0000_0100, 32'h0000_0100, 32'h0001_0000, 32'h0001_0000));

    for (int set = 0; set < 8; set++) begin
      case (set)
        0: load_setting(TIME_STEP_RESET, CELL_WIDTH_RESET, CELL_HEIGHT_RESET);
        1: load_setting(32'h0000_0400, 32'h0000_8000, 32'h0002_0000);
        2: load_setting(MAX_REG, 1, MAX_REG);
        3: load_setting(0, MAX_REG, 1);
        default: load_setting($urandom_range(32'h0004_0000), $urandom_range(32'h0004_0000),
                              $urandom_range(32'h0004_0000));
      endcase
      case (set % 3)
        0: begin
          send_idle_pct  = 11;
          recv_stall_pct = 65;
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < CELLS_PER_SET; n++) send_cell(random_cell());
    end

    drain();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
